[sv/ppvt_pkg.sv]
// Shared constants, types and helpers for the planar projection vertex transform.
package ppvt_pkg;

   localparam int FRAC_BITS_DEF = 12;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_KIND     = 3'd0;
   localparam logic [2:0] REG_SOURCE_X = 3'd1;
   localparam logic [2:0] REG_SOURCE_Y = 3'd2;
   localparam logic [2:0] REG_SOURCE_Z = 3'd3;
   localparam logic [2:0] REG_NORMAL_X = 3'd4;
   localparam logic [2:0] REG_NORMAL_Y = 3'd5;
   localparam logic [2:0] REG_NORMAL_Z = 3'd6;
   localparam logic [2:0] REG_OFFSET   = 3'd7;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Widths of the intermediate terms.
   localparam int DOT_W  = 35;  // sum of three 16x16 products
   localparam int SUM_W  = 36;  // scale, mix, w
   localparam int NUM_W  = 54;  // scale*v + s*mix
   localparam int QUO_W  = 18;  // quotient magnitude, wide enough to see overflow

   // Configuration seen by the datapath.
   typedef struct packed {
      logic               kind;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic signed [15:0] src_z;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic signed [31:0] offset;
   } cfg_type;

endpackage

[sv/ppvt_front.sv]
// Front stages: dot products, then scale/mix/w, then the three numerators.
module ppvt_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  ppvt_pkg::cfg_type                    cfg,
   input  logic signed [15:0]                   vx,
   input  logic signed [15:0]                   vy,
   input  logic signed [15:0]                   vz,
   output logic                                 out_valid,
   output logic signed [ppvt_pkg::NUM_W-1:0]    num_x,
   output logic signed [ppvt_pkg::NUM_W-1:0]    num_y,
   output logic signed [ppvt_pkg::NUM_W-1:0]    num_z,
   output logic signed [ppvt_pkg::SUM_W-1:0]    den
);

   localparam int DW = ppvt_pkg::DOT_W;
   localparam int SW = ppvt_pkg::SUM_W;
   localparam int NW = ppvt_pkg::NUM_W;

   // Stage 1: n.v and n.s
   logic                 v1_ff;
   logic signed [DW-1:0] nv_ff, d1_ff;
   logic signed [15:0]   ax_ff, ay_ff, az_ff;
   logic signed [DW-1:0] nv_in, d1_in;

   assign nv_in = DW'(cfg.nrm_x * vx) + DW'(cfg.nrm_y * vy) + DW'(cfg.nrm_z * vz);
   assign d1_in = DW'(cfg.nrm_x * cfg.src_x) + DW'(cfg.nrm_y * cfg.src_y)
                + DW'(cfg.nrm_z * cfg.src_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         nv_ff <= nv_in;
         d1_ff <= d1_in;
         ax_ff <= vx;
         ay_ff <= vy;
         az_ff <= vz;
      end
   end

   // Stage 2: pick scale, mix and w for the mode
   logic                 v2_ff;
   logic signed [SW-1:0] scale_ff, mix_ff, w_ff;
   logic signed [SW-1:0] scale_in, mix_in, w_in, d0, nv, d1;
   logic signed [15:0]   bx_ff, by_ff, bz_ff;

   assign d0 = SW'(cfg.offset);
   assign nv = SW'(nv_ff);
   assign d1 = SW'(d1_ff);

   always_comb begin
      if (!cfg.kind) begin
         scale_in = d0 - d1;
         mix_in   = nv - d0;
         w_in     = nv - d1;
      end else begin
         scale_in = d1;
         mix_in   = d0 - nv;
         w_in     = d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         scale_ff <= scale_in;
         mix_ff   <= mix_in;
         w_ff     <= w_in;
         bx_ff    <= ax_ff;
         by_ff    <= ay_ff;
         bz_ff    <= az_ff;
      end
   end

   // Stage 3: products, registered before the add
   logic                 v3_ff;
   logic signed [NW-1:0] px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff;
   logic signed [SW-1:0] w3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         px_ff <= NW'(scale_ff * bx_ff);
         py_ff <= NW'(scale_ff * by_ff);
         pz_ff <= NW'(scale_ff * bz_ff);
         qx_ff <= NW'(mix_ff * cfg.src_x);
         qy_ff <= NW'(mix_ff * cfg.src_y);
         qz_ff <= NW'(mix_ff * cfg.src_z);
         w3_ff <= w_ff;
      end
   end

   // Stage 4: sums
   logic                 v4_ff;
   logic signed [NW-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [SW-1:0] w4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         nx_ff <= px_ff + qx_ff;
         ny_ff <= py_ff + qy_ff;
         nz_ff <= pz_ff + qz_ff;
         w4_ff <= w3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign num_x     = nx_ff;
   assign num_y     = ny_ff;
   assign num_z     = nz_ff;
   assign den       = w4_ff;

endmodule

[sv/ppvt_divider.sv]
// Pipelined restoring divider: rounded quotient with sign, saturation flag.
module ppvt_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [ppvt_pkg::NUM_W-1:0]    num,
   input  logic signed [ppvt_pkg::SUM_W-1:0]    den,
   output logic                                 out_valid,
   output logic signed [15:0]                   quo,
   output logic                                 sat
);

   localparam int NW = ppvt_pkg::NUM_W;
   localparam int SW = ppvt_pkg::SUM_W;
   localparam int QW = ppvt_pkg::QUO_W;
   // Magnitudes: numerator up to 2^(NW-1) plus half divisor
   localparam int MW = NW + 1;
   localparam int DW = SW;

   // Entry stage: magnitudes with rounding bias
   logic          e_valid_ff;
   logic [MW-1:0] e_num_ff;
   logic [DW-1:0] e_den_ff;
   logic          e_neg_ff;
   logic [NW-1:0] un;
   logic [DW-1:0] ud;

   assign un = num[NW-1] ? NW'(-num) : NW'(num);
   assign ud = den[SW-1] ? DW'(-den) : DW'(den);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= in_valid;
      end
      if (advance) begin
         e_num_ff <= MW'(un) + MW'(ud >> 1);
         e_den_ff <= ud;
         e_neg_ff <= num[NW-1] ^ den[SW-1];
      end
   end

   // Any quotient bit above QW means saturation; fold those into a flag
   // with one wide compare, then extract QW quotient bits a step each.
   logic          h_valid_ff;
   logic          h_big_ff;
   logic [MW-1:0] h_num_ff;
   logic [DW-1:0] h_den_ff;
   logic          h_neg_ff;
   logic [MW+QW-1:0] lim;

   assign lim = (MW+QW)'(e_den_ff) << QW;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         h_valid_ff <= e_valid_ff;
      end
      if (advance) begin
         h_big_ff <= (MW+QW)'(e_num_ff) >= lim;
         h_num_ff <= e_num_ff;
         h_den_ff <= e_den_ff;
         h_neg_ff <= e_neg_ff;
      end
   end

   // QW steps of one bit each
   logic          s_valid_ff [QW+1];
   logic [MW-1:0] s_rem_ff   [QW+1];
   logic [QW-1:0] s_quo_ff   [QW+1];
   logic [DW-1:0] s_den_ff   [QW+1];
   logic          s_neg_ff   [QW+1];
   logic          s_big_ff   [QW+1];

   always_comb begin
      s_valid_ff[0] = h_valid_ff;
      s_rem_ff[0]   = h_num_ff;
      s_quo_ff[0]   = '0;
      s_den_ff[0]   = h_den_ff;
      s_neg_ff[0]   = h_neg_ff;
      s_big_ff[0]   = h_big_ff;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      logic [MW+QW-1:0] trial;
      logic             fits;
      assign trial = (MW+QW)'(s_den_ff[k]) << SH;
      assign fits  = (MW+QW)'(s_rem_ff[k]) >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            s_valid_ff[k+1] <= s_valid_ff[k];
         end
         if (advance) begin
            s_rem_ff[k+1] <= fits ? MW'((MW+QW)'(s_rem_ff[k]) - trial) : s_rem_ff[k];
            s_quo_ff[k+1] <= s_quo_ff[k] | (QW'(fits) << SH);
            s_den_ff[k+1] <= s_den_ff[k];
            s_neg_ff[k+1] <= s_neg_ff[k];
            s_big_ff[k+1] <= s_big_ff[k];
         end
      end
   end

   // Sign and clamp
   logic          f_valid_ff;
   logic [15:0]   f_quo_ff;
   logic          f_sat_ff;
   logic [QW-1:0] q;
   logic          over;
   logic [15:0]   qv;

   assign q = s_quo_ff[QW];

   always_comb begin
      if (s_neg_ff[QW]) begin
         over = s_big_ff[QW] || (q > QW'(32768));
         qv   = over ? 16'h8000 : 16'(-q);
      end else begin
         over = s_big_ff[QW] || (q > QW'(32767));
         qv   = over ? 16'h7fff : q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= s_valid_ff[QW];
      end
      if (advance) begin
         f_quo_ff <= qv;
         f_sat_ff <= over;
      end
   end

   assign out_valid = f_valid_ff;
   assign quo       = f_quo_ff;
   assign sat       = f_sat_ff;

endmodule

[sv/planar_projection_vertex_transform.sv]
// Top level of the planar projection vertex transform.
// Takes one vertex per clock unless stalled and returns one projected vertex per vertex, in order. The
// pipeline has four front stages (dot products, mode select, products, sums) and 21
// divider stages (bias, overflow check, one quotient bit per stage over 18 bits, clamp);
// the one-bit-per-stage divider sets the depth. A stall on rsp_ holds the whole pipeline
// and req_stall follows it. Configuration is latched from the csr_ port, always ready.
module planar_projection_vertex_transform #(
   parameter int FRAC_BITS = ppvt_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [15:0]                     req_vertex_x,
   input  logic signed [15:0]                     req_vertex_y,
   input  logic signed [15:0]                     req_vertex_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [15:0]                     rsp_proj_x,
   output logic signed [15:0]                     rsp_proj_y,
   output logic signed [15:0]                     rsp_proj_z,
   output logic                                   rsp_w_zero,
   output logic                                   rsp_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ppvt_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [ppvt_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int NW = ppvt_pkg::NUM_W;
   localparam int SW = ppvt_pkg::SUM_W;
   localparam int DIV_LAT = ppvt_pkg::QUO_W + 3;
   // Unit normal along z at reset
   localparam logic signed [15:0] NRM_ONE = 16'(1 << FRAC_BITS);

   // Configuration registers
   ppvt_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kind: 1'b0, src_x: '0, src_y: '0, src_z: '0, nrm_x: '0,
                     nrm_y: '0, nrm_z: NRM_ONE, offset: '0};
      end else if (csr_valid && csr_index[3] == 1'b0) begin
         case (csr_index[2:0])
            ppvt_pkg::REG_KIND:     cfg_ff.kind   <= csr_data[0];
            ppvt_pkg::REG_SOURCE_X: cfg_ff.src_x  <= csr_data[15:0];
            ppvt_pkg::REG_SOURCE_Y: cfg_ff.src_y  <= csr_data[15:0];
            ppvt_pkg::REG_SOURCE_Z: cfg_ff.src_z  <= csr_data[15:0];
            ppvt_pkg::REG_NORMAL_X: cfg_ff.nrm_x  <= csr_data[15:0];
            ppvt_pkg::REG_NORMAL_Y: cfg_ff.nrm_y  <= csr_data[15:0];
            ppvt_pkg::REG_NORMAL_Z: cfg_ff.nrm_z  <= csr_data[15:0];
            ppvt_pkg::REG_OFFSET:   cfg_ff.offset <= csr_data;
            default: ;
         endcase
      end
   end

   // Whole pipeline advances unless a finished result is stalled
   logic advance;
   logic out_v;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic                 f_valid;
   logic signed [NW-1:0] num_x, num_y, num_z;
   logic signed [SW-1:0] den;

   ppvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .cfg       (cfg_ff),
      .vx        (req_vertex_x),
      .vy        (req_vertex_y),
      .vz        (req_vertex_z),
      .out_valid (f_valid),
      .num_x     (num_x),
      .num_y     (num_y),
      .num_z     (num_z),
      .den       (den)
   );

   // Zero denominator rides along the divider depth
   logic [DIV_LAT-1:0] wz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         wz_ff <= {wz_ff[DIV_LAT-2:0], den == '0};
      end
   end

   logic        vx_o, vy_o, vz_o, sx, sy, sz;
   logic [15:0] qx, qy, qz;

   ppvt_divider u_div_x (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(f_valid),
      .num(num_x), .den(den), .out_valid(vx_o), .quo(qx), .sat(sx));
   ppvt_divider u_div_y (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(f_valid),
      .num(num_y), .den(den), .out_valid(vy_o), .quo(qy), .sat(sy));
   ppvt_divider u_div_z (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(f_valid),
      .num(num_z), .den(den), .out_valid(vz_o), .quo(qz), .sat(sz));

   logic wz;
   assign wz    = wz_ff[DIV_LAT-1];
   assign out_v = vx_o & vy_o & vz_o;

   // Force zeros when w is zero
   assign rsp_valid     = out_v;
   assign rsp_proj_x    = wz ? 16'sd0 : qx;
   assign rsp_proj_y    = wz ? 16'sd0 : qy;
   assign rsp_proj_z    = wz ? 16'sd0 : qz;
   assign rsp_w_zero    = wz;
   assign rsp_saturated = !wz && (sx || sy || sz);

endmodule

[sv/ppvt_checker.sv]
// Port-level checker for the planar projection vertex transform, bound to the top level.
module ppvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_proj_x,
   input logic [15:0] rsp_proj_y,
   input logic [15:0] rsp_proj_z,
   input logic        rsp_w_zero,
   input logic        rsp_saturated
);

   a_stall_follow: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall)) else $error("req_stall mismatch");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_w_zero |-> rsp_proj_x == 16'd0 && rsp_proj_y == 16'd0
      && rsp_proj_z == 16'd0 && !rsp_saturated) else $error("w zero not clean");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_proj_x))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("valid after reset");

endmodule

bind planar_projection_vertex_transform ppvt_checker u_ppvt_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_proj_x(rsp_proj_x), .rsp_proj_y(rsp_proj_y),
   .rsp_proj_z(rsp_proj_z), .rsp_w_zero(rsp_w_zero), .rsp_saturated(rsp_saturated));
